// File: hdl/psv_pkg.sv
package psv_pkg;

    localparam int VOICE_COUNT = 12;
    localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

    typedef enum logic [1:0] {
        CMD_PRESS  = 2'd0,
        CMD_ECHO   = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        WAVE_SAW    = 2'd0,
        WAVE_SINE   = 2'd1,
        WAVE_SQUARE = 2'd2,
        WAVE_TRI    = 2'd3
    } wave_t;

    localparam logic [1:0] CFG_WAVE_SELECT = 2'd0;
    localparam logic [1:0] CFG_SAMPLE_RATE = 2'd1;
    localparam logic [1:0] CFG_ECHO_SPAN   = 2'd2;

    localparam logic [1:0] VS_FREE = 2'd0;
    localparam logic [1:0] VS_ECHO = 2'd1;
    localparam logic [1:0] VS_HELD = 2'd2;

    localparam logic [4:0]  ATTEN_RESET = 5'd24;
    localparam logic [4:0]  ATTEN_MAX   = 5'd31;
    localparam logic [4:0]  SHIFT_TRI   = 5'd21;
    localparam logic [4:0]  SHIFT_PLAIN = 5'd24;
    localparam logic [31:0] PHASE_MAX   = 32'd2147483647;
    localparam logic [31:0] STEP_UNIT   = 32'd4294967;
    // floor(f/22) for f < 2^15 as (f * 47663) >> 20
    localparam logic [15:0] RATIO_RECIP = 16'd47663;
    // floor(y/3) for y < 2^31 as (y * 0x55555556) >> 32; x/6 is (x >> 1)/3
    localparam logic [31:0] THIRD_RECIP = 32'h5555_5556;
    localparam int          BEND_CENTER = 532;
    localparam int          BEND_GAIN   = 10000;
    // floor(x/100) for x < 1024 as (x * 1311) >> 17
    localparam logic [10:0] BEND_RECIP  = 11'd1311;
    localparam logic [3:0]  COARSE_OFS  = 4'd5;
    // half of the sine amplitude unit 21474836
    localparam int          SINE_HALF_UNIT = 10737418;

    localparam int SINE_BOUND [32] = '{
        30, 60, 90, 130, 160, 190, 220, 250, 280, 310, 340, 380, 410, 440, 470, 500,
        530, 560, 590, 630, 660, 690, 720, 750, 780, 810, 840, 880, 910, 940, 970, 1000};
    localparam int SINE_LEVEL [32] = '{
        10, 29, 47, 63, 77, 88, 95, 99, 99, 95, 88, 77, 63, 47, 29, 10,
        -10, -29, -47, -63, -77, -88, -95, -99, -99, -95, -88, -77, -63, -47, -29, -10};

    typedef struct packed {
        logic [1:0]  wave_select;
        logic [15:0] sample_rate;
        logic [31:0] echo_span;
    } cfg_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [2:0]  key_octave;
        logic [3:0]  key_note;
        logic [11:0] base_freq;
        logic [9:0]  pitch_bend;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  note;
        logic [2:0]  octave;
        logic [31:0] phase;
        logic [31:0] life;
        logic [4:0]  atten;
        logic [15:0] half;
        logic [31:0] count;
        logic [15:0] ratio;
        logic [31:0] step;
        logic        dir;
    } voice_t;

    localparam voice_t VOICE_RESET = '{
        status: VS_FREE, note: 4'd0, octave: 3'd0, phase: 32'd0, life: 32'd0,
        atten: ATTEN_RESET, half: 16'd0, count: 32'd0, ratio: 16'd0, step: 32'd0,
        dir: 1'b0};

    typedef enum logic [3:0] {
        S_IDLE,
        S_HP_DIV,
        S_STEP,
        S_ES_DIV,
        S_PREP,
        S_RD,
        S_CHK,
        S_T1,
        S_T2,
        S_OUT
    } psv_state_t;

    // sine sample already halved: level * unit >>> 1
    function automatic logic [31:0] sine_half(input logic [15:0] idx);
        logic [31:0] v;
        v = '0;
        for (int k = 31; k >= 0; k--) begin
            if ({16'b0, idx} < $unsigned(SINE_BOUND[k])) begin
                v = 32'(SINE_LEVEL[k] * SINE_HALF_UNIT);
            end
        end
        return v;
    endfunction

endpackage

// File: hdl/polyphonic_voice_synth.sv
// Sequence: a key press waits on the sample_rate divider, then scans the voices from voice 0
//   until it finds a free one. Key echo scans every voice and key remove scans until its first
//   match, no result. A sample tick runs the setup states S_ES_DIV and S_PREP, a read-modify-write
//   of the voice memory for each voice (S_RD, S_CHK, S_T1, S_T2), then loads m_ in S_OUT.
// Flow: one item at a time; s_ready is high only while idle, so no new item is taken before the last ends.
// Reset: aresetn synchronous, active low; all voices read as free at once (per-entry valid bits).
module polyphonic_voice_synth
    import psv_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // item input
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic [2:0]         s_key_octave,
    input  logic [3:0]         s_key_note,
    input  logic [11:0]        s_base_freq,
    input  logic [9:0]         s_pitch_bend,
    // sample output
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_sample_sum,
    // register writes
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_wdata
);

    cfg_t        cfg_reg;
    item_t       item;
    logic        out_free;
    logic        out_push;
    logic [31:0] out_sum;
    logic        m_valid_reg;
    logic [31:0] m_sum_reg;

    // bundle the item fields for the sequencer
    assign item = '{cmd: cmd_t'(s_cmd), key_octave: s_key_octave, key_note: s_key_note,
                    base_freq: s_base_freq, pitch_bend: s_pitch_bend};

    // configuration registers; writes beyond the list drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wave_select <= 2'd0;
            cfg_reg.sample_rate <= 16'd22000;
            cfg_reg.echo_span   <= 32'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_WAVE_SELECT: cfg_reg.wave_select <= cfg_wdata[1:0];
                CFG_SAMPLE_RATE: cfg_reg.sample_rate <= cfg_wdata[15:0];
                CFG_ECHO_SPAN:   cfg_reg.echo_span   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer with the voice memory and the half-period divider
    psv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .item     (item),
        .cfg      (cfg_reg),
        .out_free (out_free),
        .out_push (out_push),
        .out_sum  (out_sum)
    );

    // output register: hold the sample until taken, refill in the same cycle it drains
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_push) begin
            m_sum_reg <= out_sum;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_sum = $signed(m_sum_reg);

endmodule

// File: hdl/psv_voice_ram.sv
module psv_voice_ram
    import psv_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [VIDX_W-1:0] wr_addr,
    input  voice_t            wr_data,
    input  logic              rd_en,
    input  logic [VIDX_W-1:0] rd_addr,
    output voice_t            rd_data
);

    voice_t                 mem [VOICE_COUNT];
    logic [VOICE_COUNT-1:0] valid_reg;
    voice_t                 rd_data_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // never-written entries read as the reset voice
    assign rd_data = rd_valid_reg ? rd_data_reg : VOICE_RESET;

endmodule

// File: hdl/psv_div.sv
module psv_div
    import psv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [31:0] quotient
);

    logic [31:0] quo_reg;
    logic [15:0] rem_reg;
    logic [15:0] dvs_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [16:0] trial;
    logic [16:0] diff;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, quo_reg[31]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_reg <= diff[15:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end else begin
                rem_reg <= trial[15:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == 5'd31);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hdl/psv_ctrl.sv
module psv_ctrl
    import psv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  item_t       item,
    input  cfg_t        cfg,
    input  logic        out_free,
    output logic        out_push,
    output logic [31:0] out_sum
);

    localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(VOICE_COUNT - 1);

    psv_state_t        state_reg, state_next;
    item_t             item_reg, item_cur;
    logic              accept;
    logic [VIDX_W-1:0] idx_reg;

    logic [15:0] half_reg;
    logic [15:0] ratio_reg;
    logic [31:0] step_reg;
    logic [31:0] span6_reg;
    logic [31:0] th_reg [5];
    logic [31:0] bend_shift_reg;
    logic [3:0]  coarse_reg;
    logic [31:0] sum_reg;

    voice_t      rec_reg;
    logic [15:0] sidx_reg;
    logic [31:0] p_reg;
    logic [31:0] shifted_reg;
    voice_t      nw_reg;
    logic [31:0] ph_reg;
    logic [4:0]  sh_reg;

    logic        div_start, div_busy, div_done;
    logic [31:0] div_dividend, div_q;
    logic [15:0] div_divisor;

    logic        ram_we, ram_re;
    voice_t      ram_wdata, ram_rdata;

    logic        chk_write, chk_stop, chk_match;
    voice_t      chk_rec;

    voice_t      nw;
    logic [31:0] ph;
    logic [4:0]  sh;
    logic        hit;
    logic [31:0] coarse32;
    logic [20:0] bend_prod;
    logic signed [10:0] bend_ofs;
    logic [30:0] ratio_prod;
    logic [62:0] span_prod;

    function automatic logic [14:0] f_of(input item_t it);
        logic [14:0] f;
        if (it.key_octave > 3'd4) begin
            f = {3'b0, it.base_freq} << (it.key_octave - 3'd4);
        end else begin
            f = {3'b0, it.base_freq} >> (3'd4 - it.key_octave);
        end
        return f;
    endfunction

    // signed halving that truncates toward zero
    function automatic logic [31:0] tri_half(input logic [31:0] p);
        logic [31:0] a;
        a = p + {31'b0, p[31]};
        return {a[31], a[31:1]};
    endfunction

    assign accept   = in_valid && in_ready;
    assign item_cur = accept ? item : item_reg;
    assign coarse32 = {{28{coarse_reg[3]}}, coarse_reg};

    psv_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    psv_voice_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (ram_we),
        .wr_addr (idx_reg),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (idx_reg),
        .rd_data (ram_rdata)
    );

    // key command decision on the voice just read
    always_comb begin
        chk_match = (ram_rdata.status != VS_FREE) && (ram_rdata.octave == item_reg.key_octave)
                    && (ram_rdata.note == item_reg.key_note);
        chk_rec   = ram_rdata;
        chk_write = 1'b0;
        chk_stop  = 1'b0;
        unique case (item_reg.cmd)
            CMD_PRESS: begin
                if (ram_rdata.status == VS_FREE) begin
                    chk_rec.status = VS_HELD;
                    chk_rec.note   = item_reg.key_note;
                    chk_rec.octave = item_reg.key_octave;
                    chk_rec.atten  = ATTEN_RESET;
                    chk_rec.dir    = 1'b0;
                    chk_rec.count  = '0;
                    chk_rec.half   = half_reg;
                    chk_rec.ratio  = ratio_reg;
                    chk_rec.step   = step_reg;
                    chk_write      = 1'b1;
                    chk_stop       = 1'b1;
                end
            end
            CMD_ECHO: begin
                if (chk_match) begin
                    chk_rec.status = VS_ECHO;
                    chk_rec.life   = cfg.echo_span;
                    chk_write      = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (chk_match) begin
                    chk_rec       = VOICE_RESET;
                    chk_rec.atten = ram_rdata.atten;
                    chk_write     = 1'b1;
                    chk_stop      = 1'b1;
                end
            end
            CMD_TICK: begin
                chk_write = 1'b0;
            end
        endcase
    end

    // waveform step for the voice held in rec_reg
    always_comb begin
        nw  = rec_reg;
        ph  = rec_reg.phase;
        hit = 1'b0;
        unique case (wave_t'(cfg.wave_select))
            WAVE_SAW: begin
                ph = rec_reg.phase + shifted_reg;
            end
            WAVE_SINE: begin
                ph = sine_half(sidx_reg);
                if (rec_reg.count >= {15'b0, rec_reg.half, 1'b0}) begin
                    nw.count = '0;
                end else begin
                    nw.count = rec_reg.count + 32'd1;
                end
            end
            WAVE_SQUARE: begin
                ph = (rec_reg.phase == '0) ? PHASE_MAX : rec_reg.phase;
                if (rec_reg.count == ({16'b0, rec_reg.half} + coarse32)) begin
                    ph       = 32'd0 - ph;
                    nw.count = '0;
                end else begin
                    nw.count = rec_reg.count + 32'd1;
                end
            end
            WAVE_TRI: begin
                ph = (rec_reg.phase == '0) ? tri_half(p_reg) : rec_reg.phase;
                if (rec_reg.count == {16'b0, rec_reg.half}) begin
                    nw.dir = 1'b1;
                end else if (rec_reg.count == {15'b0, rec_reg.half, 1'b0}) begin
                    nw.dir   = 1'b0;
                    nw.count = '0;
                end
                nw.count = nw.count + 32'd1;
                ph = nw.dir ? (ph - shifted_reg) : (ph + shifted_reg);
            end
        endcase
        nw.phase = ph;
        if (rec_reg.status == VS_ECHO) begin
            for (int k = 0; k < 5; k++) begin
                if (rec_reg.life == th_reg[k]) begin
                    hit = 1'b1;
                end
            end
            if (hit && (rec_reg.atten < ATTEN_MAX)) begin
                nw.atten = rec_reg.atten + 5'd1;
            end
            sh = nw.atten;
            if (rec_reg.life == '0) begin
                nw       = VOICE_RESET;
                nw.atten = sh;
            end else begin
                nw.life = rec_reg.life - 32'd1;
            end
        end else begin
            sh = (wave_t'(cfg.wave_select) == WAVE_TRI) ? SHIFT_TRI : SHIFT_PLAIN;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (item.cmd)
                        CMD_PRESS:  state_next = S_HP_DIV;
                        CMD_ECHO:   state_next = S_RD;
                        CMD_REMOVE: state_next = S_RD;
                        CMD_TICK:   state_next = S_ES_DIV;
                    endcase
                end
            end
            S_HP_DIV: if (div_done) state_next = S_STEP;
            S_STEP:   state_next = S_RD;
            S_ES_DIV: state_next = S_PREP;
            S_PREP:   state_next = S_RD;
            S_RD:     state_next = S_CHK;
            S_CHK: begin
                if (item_reg.cmd == CMD_TICK) begin
                    state_next = S_T1;
                end else if (chk_stop || (idx_reg == LAST_VOICE)) begin
                    state_next = S_IDLE;
                end else begin
                    state_next = S_RD;
                end
            end
            S_T1:     state_next = S_T2;
            S_T2:     state_next = (idx_reg == LAST_VOICE) ? S_OUT : S_RD;
            S_OUT:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        in_ready     = (state_reg == S_IDLE);
        ram_re       = (state_reg == S_RD);
        ram_we       = ((state_reg == S_CHK) && chk_write)
                       || ((state_reg == S_T2) && (rec_reg.status != VS_FREE));
        ram_wdata    = (state_reg == S_T2) ? nw_reg : chk_rec;
        out_push     = (state_reg == S_OUT) && out_free;
        div_start    = (state_next != state_reg) && (state_next == S_HP_DIV);
        div_dividend = {16'b0, cfg.sample_rate};
        div_divisor  = {f_of(item_cur), 1'b0};
    end

    assign out_sum    = sum_reg;
    assign bend_ofs   = 11'(BEND_CENTER) - $signed({1'b0, item_reg.pitch_bend});
    assign bend_prod  = {11'b0, item_reg.pitch_bend} * {10'b0, BEND_RECIP};
    assign ratio_prod = {16'b0, f_of(item_reg)} * {15'b0, RATIO_RECIP};
    assign span_prod  = {32'b0, cfg.echo_span[31:1]} * {31'b0, THIRD_RECIP};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item;
        end
        unique case (state_reg)
            S_IDLE: idx_reg <= '0;
            S_HP_DIV: begin
                if (div_done) begin
                    half_reg  <= (f_of(item_reg) == '0) ? 16'd0 : div_q[15:0];
                    ratio_reg <= {5'b0, ratio_prod[30:20]};
                end
            end
            S_STEP:   step_reg <= 32'({16'b0, ratio_reg} * STEP_UNIT);
            S_ES_DIV: span6_reg <= {1'b0, span_prod[62:32]};
            S_PREP: begin
                th_reg[0]      <= cfg.echo_span - span6_reg;
                th_reg[1]      <= cfg.echo_span - (span6_reg << 1);
                th_reg[2]      <= cfg.echo_span - (span6_reg + (span6_reg << 1));
                th_reg[3]      <= cfg.echo_span - (span6_reg << 2);
                th_reg[4]      <= cfg.echo_span - (span6_reg + (span6_reg << 2));
                bend_shift_reg <= 32'({{21{bend_ofs[10]}}, bend_ofs} * 32'(BEND_GAIN));
                coarse_reg     <= bend_prod[20:17] - COARSE_OFS;
                sum_reg        <= '0;
            end
            S_RD: ;
            S_CHK: begin
                rec_reg     <= ram_rdata;
                sidx_reg    <= 16'(ram_rdata.count[15:0]
                               * (ram_rdata.ratio + {{12{coarse_reg[3]}}, coarse_reg}));
                p_reg       <= 32'((32'd0 - ram_rdata.step) * {16'b0, ram_rdata.half});
                shifted_reg <= ram_rdata.step + bend_shift_reg;
                if ((item_reg.cmd != CMD_TICK) && (idx_reg != LAST_VOICE)) begin
                    idx_reg <= idx_reg + VIDX_W'(1);
                end
            end
            S_T1: begin
                nw_reg <= nw;
                ph_reg <= ph;
                sh_reg <= sh;
            end
            S_T2: begin
                if (rec_reg.status != VS_FREE) begin
                    sum_reg <= sum_reg + 32'($signed(ph_reg) >>> sh_reg);
                end
                if (idx_reg != LAST_VOICE) begin
                    idx_reg <= idx_reg + VIDX_W'(1);
                end
            end
            S_OUT: ;
            default: ;
        endcase
    end

    ap_we_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_CHK) || (state_reg == S_T2))
        else $error("voice write outside a write state");

    ap_push_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        out_push |-> (item_reg.cmd == CMD_TICK))
        else $error("result pushed for a key command");

    ap_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !div_busy)
        else $error("divider busy while idle");

    ap_accept_leave: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted item not started");

endmodule

// File: dv/polyphonic_voice_synth_tb.sv
module polyphonic_voice_synth_tb;
    import psv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV          = VOICE_COUNT;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int HOLD_CYCLES = 400;
    // longest no-result command scans every voice; allow well past that
    localparam int SETTLE      = 150;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_cmd;
    logic [2:0]         s_key_octave;
    logic [3:0]         s_key_note;
    logic [11:0]        s_base_freq;
    logic [9:0]         s_pitch_bend;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_sample_sum;
    logic               cfg_wr_en;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_wdata;

    polyphonic_voice_synth dut (.*);

    // ------------------------------------------------------------------
    // Shadow copy of the synth: registers and per-voice state
    // ------------------------------------------------------------------
    logic [1:0]  sh_wave;
    logic [31:0] sh_rate;
    logic [31:0] sh_span;
    logic [1:0]  v_status [NV];
    logic [3:0]  v_note   [NV];
    logic [2:0]  v_oct    [NV];
    logic [31:0] v_phase  [NV];
    logic [31:0] v_life   [NV];
    logic [31:0] v_atten  [NV];
    logic [31:0] v_half   [NV];
    logic [31:0] v_count  [NV];
    logic [31:0] v_ratio  [NV];
    logic [31:0] v_step   [NV];
    logic        v_dir    [NV];

    item_t       item_backlog [$];
    logic [31:0] sum_expected [$];

    int  mismatches;
    int  send_gap;
    int  recv_gap;
    int  hold_left;
    int  hold_req;
    int  hold_ack;
    bit  no_idle;
    bit  send_pause;
    longint cycles;

    // Sine lookup: 32 segments over a period of 1000 steps
    function automatic logic [31:0] sine_amp(input logic [31:0] idx);
        int bounds [32] = '{30, 60, 90, 130, 160, 190, 220, 250, 280, 310, 340, 380,
                            410, 440, 470, 500, 530, 560, 590, 630, 660, 690, 720, 750,
                            780, 810, 840, 880, 910, 940, 970, 1000};
        int levels [32] = '{10, 29, 47, 63, 77, 88, 95, 99, 99, 95, 88, 77, 63, 47, 29, 10,
                            -10, -29, -47, -63, -77, -88, -95, -99, -99, -95, -88, -77,
                            -63, -47, -29, -10};
        for (int k = 0; k < 32; k++) begin
            if (idx < 32'(bounds[k])) begin
                return 32'(levels[k]) * 32'd21474836;
            end
        end
        return 32'd0;
    endfunction

    function automatic logic [31:0] sra(input logic [31:0] v, input logic [31:0] n);
        return $signed(v) >>> n[4:0];
    endfunction

    task automatic release_voice(input int i);
        v_status[i] = VS_FREE; v_note[i] = 0; v_oct[i] = 0; v_phase[i] = 0;
        v_life[i] = 0; v_half[i] = 0; v_ratio[i] = 0; v_step[i] = 0;
        v_dir[i] = 0; v_count[i] = 0;
    endtask

    task automatic clear_voices();
        sh_wave = WAVE_SAW; sh_rate = 22000; sh_span = 0;
        for (int i = 0; i < NV; i++) begin
            release_voice(i);
            v_atten[i] = 24;
        end
    endtask

    // Advance the shadow synth by one command; a tick queues its sample
    task automatic mix_voices(input item_t it);
        logic [31:0] f, dv, bshift, coarse, sum, shifted, half, idx, p, s;
        bit hit;
        case (it.cmd)
            CMD_PRESS: begin
                for (int i = 0; i < NV; i++) begin
                    if (v_status[i] == VS_FREE) begin
                        v_status[i] = VS_HELD; v_note[i] = it.key_note;
                        v_oct[i] = it.key_octave; v_atten[i] = 24; v_dir[i] = 0;
                        v_count[i] = 0;
                        f = (it.key_octave > 4) ? (32'(it.base_freq) << (it.key_octave - 4))
                                                : (32'(it.base_freq) >> (4 - it.key_octave));
                        dv = f * 2;
                        v_half[i] = (dv == 0) ? 32'd0 : ((sh_rate / dv) & 32'hFFFF);
                        v_ratio[i] = (f / 22) & 32'hFFFF;
                        v_step[i] = 32'd4294967 * v_ratio[i];
                        break;
                    end
                end
            end
            CMD_ECHO: begin
                for (int i = 0; i < NV; i++) begin
                    if (v_status[i] != VS_FREE && v_oct[i] == it.key_octave &&
                        v_note[i] == it.key_note) begin
                        v_status[i] = VS_ECHO;
                        v_life[i] = sh_span;
                    end
                end
            end
            CMD_REMOVE: begin
                for (int i = 0; i < NV; i++) begin
                    if (v_status[i] != VS_FREE && v_oct[i] == it.key_octave &&
                        v_note[i] == it.key_note) begin
                        release_voice(i);
                        break;
                    end
                end
            end
            default: begin
                sum = 0;
                bshift = 32'((532 - int'(it.pitch_bend)) * 10000);
                coarse = 32'(it.pitch_bend) / 100 - 32'd5;
                for (int i = 0; i < NV; i++) begin
                    if (v_status[i] == VS_FREE) continue;
                    half = v_half[i];
                    shifted = v_step[i] + bshift;
                    case (sh_wave)
                        WAVE_SAW: v_phase[i] += shifted;
                        WAVE_SINE: begin
                            idx = (v_count[i] * (v_ratio[i] + coarse)) & 32'hFFFF;
                            v_phase[i] = sra(sine_amp(idx), 1);
                            if (v_count[i] >= half * 2) v_count[i] = 0;
                            else v_count[i] += 1;
                        end
                        WAVE_SQUARE: begin
                            if (v_phase[i] == 0) v_phase[i] = 32'h7FFF_FFFF;
                            if (v_count[i] == half + coarse) begin
                                v_phase[i] = -v_phase[i];
                                v_count[i] = 0;
                            end else begin
                                v_count[i] += 1;
                            end
                        end
                        default: begin
                            if (v_phase[i] == 0) begin
                                p = (-v_step[i]) * half;
                                v_phase[i] = 32'($signed(p) / 2);
                            end
                            if (v_count[i] == half) begin
                                v_dir[i] = 1;
                            end else if (v_count[i] == 2 * half) begin
                                v_dir[i] = 0;
                                v_count[i] = 0;
                            end
                            v_count[i] += 1;
                            v_phase[i] += v_dir[i] ? -shifted : shifted;
                        end
                    endcase
                    if (v_status[i] == VS_ECHO) begin
                        // decay a notch each time life crosses a sixth of the span
                        s = sh_span / 6;
                        hit = 0;
                        for (int k = 1; k <= 5; k++) begin
                            if (v_life[i] == sh_span - 32'(k) * s) hit = 1;
                        end
                        if (hit && v_atten[i] < 31) v_atten[i] += 1;
                        sum += sra(v_phase[i], v_atten[i]);
                        if (v_life[i] == 0) release_voice(i);
                        else v_life[i] -= 1;
                    end else begin
                        sum += sra(v_phase[i], (sh_wave == WAVE_TRI) ? 32'd21 : 32'd24);
                    end
                end
                sum_expected.push_back(sum);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------
    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("polyphonic_voice_synth_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: hold each item until accepted, predict on acceptance
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        item_t nxt;
        if (!aresetn) begin
            s_valid <= 0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                mix_voices(item_t'{cmd_t'(s_cmd), s_key_octave, s_key_note, s_base_freq,
                                   s_pitch_bend});
            end
            if (s_valid && !s_ready) begin
                // hold: payload stays put until accepted
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 0;
            end else if (!send_pause && item_backlog.size() > 0) begin
                nxt = item_backlog.pop_front();
                s_valid <= 1;
                s_cmd <= nxt.cmd;
                s_key_octave <= nxt.key_octave;
                s_key_note <= nxt.key_note;
                s_base_freq <= nxt.base_freq;
                s_pitch_bend <= nxt.pitch_bend;
                if (!no_idle && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 14);
            end else begin
                s_valid <= 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver and monitor
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        logic [31:0] want;
        if (!aresetn) begin
            m_ready <= 0;
            recv_gap <= 0;
            hold_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (sum_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected sample: got %0d", m_sample_sum);
                end else begin
                    want = sum_expected.pop_front();
                    if (m_sample_sum !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("sample_sum mismatch: expected %0d got %0d",
                                     $signed(want), m_sample_sum);
                    end
                end
            end
            // long hold-off so the block backs up and stalls its input
            if (hold_req != hold_ack) begin
                hold_ack <= hold_req;
                hold_left <= HOLD_CYCLES;
                m_ready <= 0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= 0;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                recv_gap <= $urandom_range(0, 13);
                m_ready <= 0;
            end else begin
                m_ready <= 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequencing
    // ------------------------------------------------------------------
    function automatic item_t make_item(input cmd_t c, input int oct, input int nt,
                                        input int fq, input int bd);
        return item_t'{c, 3'(oct), 4'(nt), 12'(fq), 10'(bd)};
    endfunction

    // well-formed traffic from a small key set so echo and remove find voices
    task automatic queue_traffic(input int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                item_backlog.push_back(item_t'(31'($urandom)));
            end else if (r < 45) begin
                item_backlog.push_back(make_item(CMD_TICK, $urandom_range(0, 7),
                    $urandom_range(0, 15), $urandom_range(0, 4095), $urandom_range(0, 1023)));
            end else begin
                item_backlog.push_back(make_item(
                    (r < 70) ? CMD_PRESS : (r < 85) ? CMD_ECHO : CMD_REMOVE,
                    $urandom_range(1, 7), $urandom_range(0, 3),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                : $urandom_range(200, 600),
                    $urandom_range(0, 1023)));
            end
        end
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (item_backlog.size() != 0 || s_valid || sum_expected.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_WAVE_SELECT: sh_wave = val[1:0];
            CFG_SAMPLE_RATE: sh_rate = val & 32'hFFFF;
            default:         sh_span = val;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 0;
    endtask

    task automatic set_regs(input logic [1:0] w, input logic [31:0] r, input logic [31:0] e);
        write_reg(CFG_WAVE_SELECT, 32'(w));
        write_reg(CFG_SAMPLE_RATE, r);
        write_reg(CFG_ECHO_SPAN, e);
    endtask

    initial begin
        mismatches = 0;
        hold_req = 0;
        hold_ack = 0;
        no_idle = 0;
        send_pause = 0;
        aresetn = 0;
        s_valid = 0;
        s_cmd = CMD_PRESS;
        s_key_octave = 0;
        s_key_note = 0;
        s_base_freq = 0;
        s_pitch_bend = 0;
        m_ready = 0;
        cfg_wr_en = 0;
        cfg_index = CFG_WAVE_SELECT;
        cfg_wdata = 0;
        clear_voices();
        repeat (6) @(posedge aclk);
        aresetn <= 1;

        // Directed: reset registers, field extremes, full voice pool, zero divisor
        item_backlog.push_back(make_item(CMD_TICK, 0, 0, 0, 532));
        item_backlog.push_back(make_item(CMD_PRESS, 0, 0, 0, 0));        // zero divisor
        item_backlog.push_back(make_item(CMD_PRESS, 7, 15, 4095, 1023));
        for (int k = 0; k < 10; k++)
            item_backlog.push_back(make_item(CMD_PRESS, 1 + k % 7, k, 262 + 17 * k, 0));
        item_backlog.push_back(make_item(CMD_PRESS, 4, 9, 440, 0));      // no free voice
        item_backlog.push_back(make_item(CMD_TICK, 0, 0, 0, 0));
        item_backlog.push_back(make_item(CMD_TICK, 7, 15, 4095, 1023));
        item_backlog.push_back(make_item(CMD_ECHO, 7, 15, 0, 0));
        item_backlog.push_back(make_item(CMD_TICK, 0, 0, 0, 532));
        item_backlog.push_back(make_item(CMD_TICK, 0, 0, 0, 499));
        item_backlog.push_back(make_item(CMD_REMOVE, 0, 0, 0, 0));
        item_backlog.push_back(make_item(CMD_REMOVE, 5, 14, 0, 0));      // no match
        item_backlog.push_back(make_item(CMD_TICK, 3, 5, 100, 700));
        drain();

        // Each setting: well-formed traffic; pressure and quiet in chosen phases
        set_regs(WAVE_SINE, 32'd1, 32'd12);
        queue_traffic(90);
        drain();

        set_regs(WAVE_SQUARE, 32'd65535, 32'hFFFF_FFFF);
        queue_traffic(45);
        hold_req = hold_req + 1;
        queue_traffic(45);
        drain();

        set_regs(WAVE_TRI, 32'd44100, 32'd30);
        queue_traffic(50);
        // let part of the traffic through, then wait for every pending sample
        while (item_backlog.size() > 20) @(posedge aclk);
        send_pause = 1;
        do @(posedge aclk); while (s_valid || sum_expected.size() != 0);
        send_pause = 0;
        queue_traffic(40);
        drain();

        set_regs(WAVE_SAW, 32'($urandom_range(1, 65535)), 32'($urandom_range(0, 200)));
        queue_traffic(90);
        drain();

        set_regs(WAVE_SINE, 32'd22000, 32'd0);
        queue_traffic(45);
        drain();

        no_idle = 1;
        set_regs(2'($urandom_range(0, 3)), 32'd8000, 32'd60);
        queue_traffic(90);
        drain();

        if (mismatches == 0) begin
            $display("polyphonic_voice_synth_tb: PASS");
        end else begin
            $display("polyphonic_voice_synth_tb: FAIL");
        end
        $finish;
    end

endmodule
